// ===== hw/rtl/nsc_pkg.sv =====
package nsc_pkg;

    // Default line capacity per slot, in bytes
    localparam int LINE_LEN_DEF = 128;

    // Header compare length and register width
    localparam int HDR_LEN = 5;
    localparam int HDR_W   = 8 * HDR_LEN;

    localparam logic [HDR_W-1:0] FIRST_HDR_RST  = 40'd306290249027; // "GPRMC"
    localparam logic [HDR_W-1:0] SECOND_HDR_RST = 40'd306289526593; // "GPGGA"

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Config port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam int REG_SEL_BIT = 3;  // registers on an 8-byte stride

    typedef logic [1:0] func_t;
    localparam func_t FUNC_BYTE    = 2'd0;
    localparam func_t FUNC_READ    = 2'd1;
    localparam func_t FUNC_RELEASE = 2'd2;

    typedef struct packed {
        logic kept;
        logic both_ready;
    } cap_status_t;

    // strncmp-style compare; first byte sits in the top byte of each word
    function automatic logic hdr_match(input logic [HDR_W-1:0] want,
                                       input logic [HDR_W-1:0] got);
        logic       done;
        logic       ok;
        logic [7:0] w;
        logic [7:0] g;
        done = 1'b0;
        ok   = 1'b1;
        for (int i = 0; i < HDR_LEN; i++) begin
            w = want[8*(HDR_LEN-1-i) +: 8];
            g = got[8*(HDR_LEN-1-i) +: 8];
            if (!done) begin
                if (w != g) begin
                    ok   = 1'b0;
                    done = 1'b1;
                end else if (w == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
        return ok;
    endfunction

endpackage

// ===== hw/rtl/nmea_sentence_capture.sv =====
// NMEA sentence capture.
// Input channel (s_*): one beat per UART byte (func = byte), per read of a stored
// byte (func = read, s_read_line / s_read_index) or per release (func = release).
// Output channel (m_*): exactly one result beat per input beat, in order.
// A '$' opens a sentence in the current slot; bytes are appended until '\n',
// which stores newline plus a zero terminator. If the five bytes after '$'
// match either header register, the slot is kept and filling moves on. After
// two kept sentences m_both_ready stays high and received bytes are ignored
// until a release beat.
// Latency: the result is valid the cycle after the input beat is taken.
// Throughput: one beat per cycle while the output is not stalled. The line store
// is split into even/odd byte banks so a newline writes both its bytes in the same
// cycle; a read reads both banks at one address, registered, and picks by index bit 0.
// Stall: s_ready = !m_valid || m_ready, so a new beat is taken in the same
// cycle the held result leaves; while m_ready is low the result holds.
// Reset (aresetn, synchronous): no open sentence, slot 0, ready clear, headers
// back to "GPRMC"/"GPGGA". The line store is not cleared, so no clearing pass.
// Config: APB, 64-bit data, first header at 0x0, second at 0x8.
module nmea_sentence_capture
    import nsc_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_read_line,
    input  logic [6:0]         s_read_index,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_read_data,
    output logic               m_both_ready,
    output logic               m_sentence_kept
);

    localparam int HALF  = (LINE_LEN + 1) / 2;   // entries per slot per bank
    localparam int POS_W = $clog2(LINE_LEN);
    localparam int BA_W  = $clog2(2 * HALF);
    localparam int IDX_W = 9;                    // holds any LINE_LEN in range

    logic [HDR_W-1:0] first_hdr, second_hdr;
    logic             acc;
    logic             wr_en   [2];
    logic [BA_W-1:0]  wr_addr [2];
    logic [7:0]       wr_data [2];
    logic [7:0]       rd_q    [2];
    cap_status_t      status;

    logic [IDX_W-1:0] idx_ext;
    logic             idx_ok;
    logic [POS_W-1:0] rd_pos;
    logic [BA_W-1:0]  rd_addr;

    logic m_valid_reg, m_valid_next;
    logic rd_use_reg, rd_sel_reg, ready_out_reg, kept_out_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign acc     = s_valid && s_ready;

    nsc_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .first_hdr  (first_hdr),
        .second_hdr (second_hdr)
    );

    nsc_capture #(
        .LINE_LEN (LINE_LEN),
        .HALF     (HALF),
        .POS_W    (POS_W),
        .BA_W     (BA_W)
    ) u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .acc        (acc),
        .func       (s_func),
        .rx_byte    (s_rx_byte),
        .first_hdr  (first_hdr),
        .second_hdr (second_hdr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .status     (status)
    );

    // Read address: index past the line reads as zero
    assign idx_ext = IDX_W'(s_read_index);
    assign idx_ok  = (idx_ext < IDX_W'(LINE_LEN));
    assign rd_pos  = idx_ext[POS_W-1:0];
    assign rd_addr = s_read_line ? BA_W'(int'(rd_pos >> 1) + HALF)
                                 : BA_W'(rd_pos >> 1);

    for (genvar b = 0; b < 2; b++) begin : g_bank
        nsc_line_bank #(
            .DEPTH (2 * HALF),
            .AW    (BA_W)
        ) u_bank (
            .aclk  (aclk),
            .we    (wr_en[b]),
            .waddr (wr_addr[b]),
            .wdata (wr_data[b]),
            .re    (acc),
            .raddr (rd_addr),
            .rdata (rd_q[b])
        );
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (acc) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_use_reg    <= (s_func == FUNC_READ) && idx_ok;
            rd_sel_reg    <= rd_pos[0];
            ready_out_reg <= status.both_ready;
            kept_out_reg  <= status.kept;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = rd_use_reg ? rd_q[rd_sel_reg] : 8'h00;
    assign m_both_ready    = ready_out_reg;
    assign m_sentence_kept = kept_out_reg;

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> m_valid)
        else $error("accepted beat produced no result");

    a_kept_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sentence_kept |-> m_read_data == 8'h00)
        else $error("kept result carries read data");

    a_kept_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && status.kept |-> s_func == FUNC_BYTE)
        else $error("sentence kept on a non-byte beat");

endmodule

// ===== hw/rtl/nsc_line_bank.sv =====
module nsc_line_bank
    import nsc_pkg::*;
#(
    parameter int DEPTH = LINE_LEN_DEF,
    parameter int AW    = $clog2(LINE_LEN_DEF)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/nsc_apb_regs.sv =====
module nsc_apb_regs
    import nsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [HDR_W-1:0]   first_hdr,
    output logic [HDR_W-1:0]   second_hdr
);

    logic [HDR_W-1:0] first_hdr_reg;
    logic [HDR_W-1:0] second_hdr_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_hdr_reg  <= FIRST_HDR_RST;
            second_hdr_reg <= SECOND_HDR_RST;
        end else if (wr_en) begin
            if (paddr[REG_SEL_BIT]) begin
                second_hdr_reg <= pwdata[HDR_W-1:0];
            end else begin
                first_hdr_reg <= pwdata[HDR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[REG_SEL_BIT]) begin
            prdata = PDATA_W'(second_hdr_reg);
        end else begin
            prdata = PDATA_W'(first_hdr_reg);
        end
    end

    assign first_hdr  = first_hdr_reg;
    assign second_hdr = second_hdr_reg;

endmodule

// ===== hw/rtl/nsc_capture.sv =====
module nsc_capture
    import nsc_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF,
    parameter int HALF     = (LINE_LEN_DEF + 1) / 2,
    parameter int POS_W    = $clog2(LINE_LEN_DEF),
    parameter int BA_W     = $clog2(LINE_LEN_DEF)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             acc,
    input  func_t            func,
    input  logic [7:0]       rx_byte,
    input  logic [HDR_W-1:0] first_hdr,
    input  logic [HDR_W-1:0] second_hdr,
    output logic             wr_en   [2],
    output logic [BA_W-1:0]  wr_addr [2],
    output logic [7:0]       wr_data [2],
    output cap_status_t      status
);

    localparam logic [POS_W-1:0] LAST_DATA = POS_W'(LINE_LEN - 2);

    logic             open_reg,  open_next;
    logic             slot_reg,  slot_next;
    logic             ready_reg, ready_next;
    logic [POS_W-1:0] wp_reg,    wp_next;
    logic [7:0]       hdr_reg [HDR_LEN];

    logic             is_byte, is_dollar, is_nl, open_now;
    logic             take, nl_take, data_take, kept;
    logic [POS_W-1:0] pos, term_pos;
    logic [HDR_W-1:0] got;

    function automatic logic [BA_W-1:0] bank_addr(input logic slot,
                                                  input logic [POS_W-1:0] p);
        int a;
        a = int'(p >> 1);
        if (slot) begin
            a = a + HALF;
        end
        return BA_W'(a);
    endfunction

    assign is_byte   = acc && (func == FUNC_BYTE) && !ready_reg;
    assign is_dollar = (rx_byte == CH_DOLLAR);
    assign is_nl     = (rx_byte == CH_NEWLINE);
    assign open_now  = is_dollar || open_reg;
    assign pos       = is_dollar ? '0 : wp_reg;
    assign term_pos  = POS_W'(pos + 1'b1);
    assign take      = is_byte && open_now;
    assign nl_take   = take && is_nl;
    assign data_take = take && !is_nl && (pos < LAST_DATA);

    // Header bytes as the slot holds them once newline and terminator land
    always_comb begin
        got = '0;
        for (int i = 1; i <= HDR_LEN; i++) begin
            if (i < int'(pos)) begin
                got[8*(HDR_LEN-i) +: 8] = hdr_reg[i-1];
            end else if (i == int'(pos)) begin
                got[8*(HDR_LEN-i) +: 8] = CH_NEWLINE;
            end else begin
                got[8*(HDR_LEN-i) +: 8] = 8'h00;
            end
        end
    end

    assign kept = nl_take && (hdr_match(first_hdr, got) || hdr_match(second_hdr, got));

    // Next state
    always_comb begin
        open_next  = open_reg;
        wp_next    = wp_reg;
        slot_next  = slot_reg;
        ready_next = ready_reg;
        if (is_byte) begin
            open_next = open_now && !is_nl;
            if (take) begin
                if (is_nl) begin
                    wp_next = '0;
                end else if (data_take) begin
                    wp_next = term_pos;
                end else begin
                    wp_next = pos;
                end
            end
        end
        if (kept) begin
            slot_next = !slot_reg;
            if (slot_reg) begin
                ready_next = 1'b1;
            end
        end
        if (acc && (func == FUNC_RELEASE)) begin
            ready_next = 1'b0;
        end
    end

    // Bank writes: even positions in bank 0, odd in bank 1
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            if (pos[0] == b[0]) begin
                wr_en[b]   = data_take || nl_take;
                wr_addr[b] = bank_addr(slot_reg, pos);
                wr_data[b] = rx_byte;
            end else begin
                wr_en[b]   = nl_take;
                wr_addr[b] = bank_addr(slot_reg, term_pos);
                wr_data[b] = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            slot_reg  <= 1'b0;
            ready_reg <= 1'b0;
            wp_reg    <= '0;
        end else begin
            open_reg  <= open_next;
            slot_reg  <= slot_next;
            ready_reg <= ready_next;
            wp_reg    <= wp_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < HDR_LEN; k++) begin
            if (data_take && (int'(pos) == k + 1)) begin
                hdr_reg[k] <= rx_byte;
            end
        end
    end

    assign status.kept       = kept;
    assign status.both_ready = ready_next;

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= LAST_DATA)
        else $error("write position past data limit");

    a_no_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> !(wr_en[0] || wr_en[1]))
        else $error("line store written while both sentences held");

    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && (func == FUNC_RELEASE) |=> !ready_reg)
        else $error("release did not clear ready");

    a_second_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        kept && slot_reg |=> ready_reg && !slot_reg)
        else $error("second kept sentence did not raise ready");

    a_kept_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        kept |-> (rx_byte == CH_NEWLINE) && (open_reg || is_dollar))
        else $error("sentence kept without a newline in an open sentence");

endmodule
